### hw/rtl/gfm_pkg.sv
// gfm_pkg: shared widths, command codes, storage slots and the inversion program
// for the 2^255-19 multiply / square / invert unit. No dependencies.
package gfm_pkg;

  localparam int WORD_W  = 32;
  localparam int NWORDS  = 9;
  localparam int ELEM_W  = WORD_W * NWORDS;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int RES_W   = 256;
  localparam int LIMB_W  = 52;
  localparam int RADIX   = 51;
  localparam int FOLD    = 19;
  localparam int SLOT_AW = 4;
  localparam int REP_W   = 7;
  localparam int STEP_W  = 5;
  localparam int LAST_STEP = 21;

  localparam logic [1:0] CMD_MUL = 2'd0;
  localparam logic [1:0] CMD_SQR = 2'd1;

  localparam logic [SLOT_AW-1:0] SLOT_X    = 4'd0;
  localparam logic [SLOT_AW-1:0] SLOT_E2   = 4'd1;
  localparam logic [SLOT_AW-1:0] SLOT_E9   = 4'd2;
  localparam logic [SLOT_AW-1:0] SLOT_E11  = 4'd3;
  localparam logic [SLOT_AW-1:0] SLOT_C5   = 4'd4;
  localparam logic [SLOT_AW-1:0] SLOT_C10  = 4'd5;
  localparam logic [SLOT_AW-1:0] SLOT_C20  = 4'd6;
  localparam logic [SLOT_AW-1:0] SLOT_C40  = 4'd7;
  localparam logic [SLOT_AW-1:0] SLOT_C50  = 4'd8;
  localparam logic [SLOT_AW-1:0] SLOT_C100 = 4'd9;
  localparam logic [SLOT_AW-1:0] SLOT_C200 = 4'd10;
  localparam logic [SLOT_AW-1:0] SLOT_C250 = 4'd11;
  localparam logic [SLOT_AW-1:0] SLOT_T    = 4'd12;
  localparam logic [SLOT_AW-1:0] SLOT_RES  = 4'd13;

  typedef struct packed {
    logic [SLOT_AW-1:0] src_a;
    logic [SLOT_AW-1:0] src_b;
    logic [SLOT_AW-1:0] dst;
    logic [REP_W-1:0]   count;
  } step_t;

  function automatic step_t prog_step(input logic [STEP_W-1:0] idx);
    step_t s;
    case (idx)
      5'd0:    s = '{SLOT_X,    SLOT_X,    SLOT_E2,   7'd1};
      5'd1:    s = '{SLOT_E2,   SLOT_E2,   SLOT_T,    7'd2};
      5'd2:    s = '{SLOT_T,    SLOT_X,    SLOT_E9,   7'd1};
      5'd3:    s = '{SLOT_E9,   SLOT_E2,   SLOT_E11,  7'd1};
      5'd4:    s = '{SLOT_E11,  SLOT_E11,  SLOT_T,    7'd1};
      5'd5:    s = '{SLOT_T,    SLOT_E9,   SLOT_C5,   7'd1};
      5'd6:    s = '{SLOT_C5,   SLOT_C5,   SLOT_T,    7'd5};
      5'd7:    s = '{SLOT_T,    SLOT_C5,   SLOT_C10,  7'd1};
      5'd8:    s = '{SLOT_C10,  SLOT_C10,  SLOT_T,    7'd10};
      5'd9:    s = '{SLOT_T,    SLOT_C10,  SLOT_C20,  7'd1};
      5'd10:   s = '{SLOT_C20,  SLOT_C20,  SLOT_T,    7'd20};
      5'd11:   s = '{SLOT_T,    SLOT_C20,  SLOT_C40,  7'd1};
      5'd12:   s = '{SLOT_C40,  SLOT_C40,  SLOT_T,    7'd10};
      5'd13:   s = '{SLOT_T,    SLOT_C10,  SLOT_C50,  7'd1};
      5'd14:   s = '{SLOT_C50,  SLOT_C50,  SLOT_T,    7'd50};
      5'd15:   s = '{SLOT_T,    SLOT_C50,  SLOT_C100, 7'd1};
      5'd16:   s = '{SLOT_C100, SLOT_C100, SLOT_T,    7'd100};
      5'd17:   s = '{SLOT_T,    SLOT_C100, SLOT_C200, 7'd1};
      5'd18:   s = '{SLOT_C200, SLOT_C200, SLOT_T,    7'd50};
      5'd19:   s = '{SLOT_T,    SLOT_C50,  SLOT_C250, 7'd1};
      5'd20:   s = '{SLOT_C250, SLOT_C250, SLOT_T,    7'd5};
      5'd21:   s = '{SLOT_T,    SLOT_E11,  SLOT_RES,  7'd1};
      default: s = '{SLOT_X,    SLOT_X,    SLOT_RES,  7'd1};
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/gf25519_mul_square_invert.sv
// gf25519_mul_square_invert: multiply or square loads the operands as 9 words, then runs
// one field product (go, product scanning on the shared 32x32 unit, two fold passes, done)
// and raises the result strobe; invert runs 265 products plus store reads of both operands
// per chain step (22 steps), after one store of the operand before the chain.
// One item at a time; busy is high from accept until the result strobe.
// Synchronous active-high reset clears control only; results are never stalled.
module gf25519_mul_square_invert
  import gfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic [LIMB_W-1:0] a_limb0,
  input  logic [LIMB_W-1:0] a_limb1,
  input  logic [LIMB_W-1:0] a_limb2,
  input  logic [LIMB_W-1:0] a_limb3,
  input  logic [LIMB_W-1:0] a_limb4,
  input  logic [LIMB_W-1:0] b_limb0,
  input  logic [LIMB_W-1:0] b_limb1,
  input  logic [LIMB_W-1:0] b_limb2,
  input  logic [LIMB_W-1:0] b_limb3,
  input  logic [LIMB_W-1:0] b_limb4,
  output logic              done,
  output logic [LIMB_W-1:0] r_limb0,
  output logic [LIMB_W-1:0] r_limb1,
  output logic [LIMB_W-1:0] r_limb2,
  output logic [LIMB_W-1:0] r_limb3,
  output logic [LIMB_W-1:0] r_limb4
);

  typedef enum logic [3:0] {
    T_IDLE, T_LOAD, T_MUL_GO, T_MUL_WAIT, T_STORE_X,
    T_RD_A, T_RD_B, T_RD_W, T_INV_GO, T_INV_WAIT
  } state_t;

  state_t             state;
  logic               inv;
  logic [LIMB_W-1:0]  al [5];
  logic [LIMB_W-1:0]  bl [5];
  logic [3:0]         w;
  logic [2:0]         cy_a, cy_b;
  logic [ELEM_W-1:0]  x, y;
  logic [STEP_W-1:0]  step;
  logic [REP_W-1:0]   rep;

  logic [34:0]        asum, bsum;
  logic [ELEM_W-1:0]  ash, bsh;
  step_t              cur;
  logic               core_go, core_done;
  logic [RES_W-1:0]   core_r;
  logic               mem_we;
  logic [SLOT_AW-1:0] mem_waddr, mem_raddr;
  logic [ELEM_W-1:0]  mem_wdata, mem_rdata;

  // overlapping 51-bit radix limbs summed one word at a time
  always_comb begin
    asum = 35'(cy_a);
    bsum = 35'(cy_b);
    for (int n = 0; n < 5; n++) begin
      ash  = ELEM_W'(al[n]) << (RADIX * n);
      bsh  = ELEM_W'(bl[n]) << (RADIX * n);
      asum = asum + 35'(ash[w*WORD_W +: WORD_W]);
      bsum = bsum + 35'(bsh[w*WORD_W +: WORD_W]);
    end
  end

  always_comb begin
    cur       = prog_step(step);
    core_go   = (state == T_MUL_GO) || (state == T_INV_GO);
    mem_we    = (state == T_STORE_X) ||
                ((state == T_INV_WAIT) && core_done && (rep <= REP_W'(1)));
    mem_waddr = (state == T_STORE_X) ? SLOT_X : cur.dst;
    mem_wdata = (state == T_STORE_X) ? x : ELEM_W'(core_r);
    mem_raddr = (state == T_RD_A) ? cur.src_a : cur.src_b;
  end

  assign busy = (state != T_IDLE);

  gfm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (core_go),
    .x    (x),
    .y    (y),
    .done (core_done),
    .r    (core_r)
  );

  gfm_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      done <= core_done && ((state == T_MUL_WAIT) ||
              ((state == T_INV_WAIT) && (rep <= REP_W'(1)) &&
               (step == STEP_W'(LAST_STEP))));
      case (state)
        T_IDLE: begin
          if (start) begin
            al[0] <= a_limb0; al[1] <= a_limb1; al[2] <= a_limb2;
            al[3] <= a_limb3; al[4] <= a_limb4;
            if (command == CMD_SQR) begin
              bl[0] <= a_limb0; bl[1] <= a_limb1; bl[2] <= a_limb2;
              bl[3] <= a_limb3; bl[4] <= a_limb4;
            end else begin
              bl[0] <= b_limb0; bl[1] <= b_limb1; bl[2] <= b_limb2;
              bl[3] <= b_limb3; bl[4] <= b_limb4;
            end
            inv   <= !((command == CMD_MUL) || (command == CMD_SQR));
            w     <= '0;
            cy_a  <= '0;
            cy_b  <= '0;
            state <= T_LOAD;
          end
        end
        T_LOAD: begin
          x[w*WORD_W +: WORD_W] <= asum[WORD_W-1:0];
          y[w*WORD_W +: WORD_W] <= bsum[WORD_W-1:0];
          cy_a <= asum[34:32];
          cy_b <= bsum[34:32];
          if (w == 4'(NWORDS - 1)) begin
            state <= inv ? T_STORE_X : T_MUL_GO;
          end else begin
            w <= w + 4'd1;
          end
        end
        T_MUL_GO: state <= T_MUL_WAIT;
        T_MUL_WAIT: begin
          if (core_done) begin
            r_limb0 <= LIMB_W'(core_r[50:0]);
            r_limb1 <= LIMB_W'(core_r[101:51]);
            r_limb2 <= LIMB_W'(core_r[152:102]);
            r_limb3 <= LIMB_W'(core_r[203:153]);
            r_limb4 <= core_r[255:204];
            state   <= T_IDLE;
          end
        end
        T_STORE_X: begin
          step  <= '0;
          state <= T_RD_A;
        end
        T_RD_A: begin
          rep   <= cur.count;
          state <= T_RD_B;
        end
        T_RD_B: begin
          x     <= mem_rdata;
          state <= T_RD_W;
        end
        T_RD_W: begin
          y     <= mem_rdata;
          state <= T_INV_GO;
        end
        T_INV_GO: state <= T_INV_WAIT;
        T_INV_WAIT: begin
          if (core_done) begin
            if (rep > REP_W'(1)) begin
              rep   <= rep - REP_W'(1);
              x     <= ELEM_W'(core_r);
              y     <= ELEM_W'(core_r);
              state <= T_INV_GO;
            end else if (step == STEP_W'(LAST_STEP)) begin
              r_limb0 <= LIMB_W'(core_r[50:0]);
              r_limb1 <= LIMB_W'(core_r[101:51]);
              r_limb2 <= LIMB_W'(core_r[152:102]);
              r_limb3 <= LIMB_W'(core_r[203:153]);
              r_limb4 <= core_r[255:204];
              state   <= T_IDLE;
            end else begin
              step  <= step + STEP_W'(1);
              state <= T_RD_A;
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/gfm_mem.sv
// gfm_mem: element store for the inversion chain, one write and one registered read port
// depends on gfm_pkg
module gfm_mem
  import gfm_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [SLOT_AW-1:0] waddr,
  input  logic [ELEM_W-1:0]  wdata,
  input  logic [SLOT_AW-1:0] raddr,
  output logic [ELEM_W-1:0]  rdata
);

  logic [ELEM_W-1:0] mem [2**SLOT_AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/gfm_core.sv
// gfm_core: word-serial field multiplier, product scanning with one 32x32 multiplier,
// then two word-serial fold passes (low 255 bits plus 19 times the rest); depends on gfm_pkg
module gfm_core
  import gfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [ELEM_W-1:0] x,
  input  logic [ELEM_W-1:0] y,
  output logic              done,
  output logic [RES_W-1:0]  r
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_RED1, S_RED2} state_t;

  state_t            state;
  logic [4:0]        k;
  logic [3:0]        i;
  logic [3:0]        w;
  logic [71:0]       acc;
  logic [PROD_W-1:0] p;
  logic [ELEM_W-1:0] rw;
  logic [5:0]        carry;

  logic [5:0]        jd;
  logic              jv;
  logic [3:0]        jsel;
  logic [WORD_W-1:0] xw, yw;
  logic [63:0]       prod;
  logic [71:0]       acc_sum;
  logic [PROD_W-1:0] lo_ext, hi_ext;
  logic [WORD_W-1:0] lo_w, hi_w;
  logic [37:0]       t;

  always_comb begin
    jd      = {1'b0, k} - {2'b0, i};
    jv      = !jd[5] && (jd[4:0] <= 5'(NWORDS - 1));
    jsel    = jv ? jd[3:0] : 4'd0;
    xw      = x[i*WORD_W +: WORD_W];
    yw      = y[jsel*WORD_W +: WORD_W];
    prod    = jv ? (64'(xw) * 64'(yw)) : 64'd0;
    acc_sum = acc + 72'(prod);
    lo_ext  = {{(PROD_W-255){1'b0}}, p[254:0]};
    hi_ext  = p >> 255;
    lo_w    = lo_ext[w*WORD_W +: WORD_W];
    hi_w    = hi_ext[w*WORD_W +: WORD_W];
    t       = 38'(lo_w) + 38'(hi_w) * 38'(FOLD) + 38'(carry);
  end

  assign r = rw[RES_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_RED2) && (w == 4'(NWORDS - 1));
      case (state)
        S_IDLE: begin
          if (go) begin
            p     <= '0;
            acc   <= '0;
            k     <= '0;
            i     <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (i == 4'(NWORDS - 1)) begin
            p[k*WORD_W +: WORD_W] <= acc_sum[WORD_W-1:0];
            acc <= acc_sum >> WORD_W;
            i   <= '0;
            if (k == 5'(2*NWORDS - 2)) begin
              w     <= '0;
              carry <= '0;
              state <= S_RED1;
            end else begin
              k <= k + 5'd1;
            end
          end else begin
            acc <= acc_sum;
            i   <= i + 4'd1;
          end
        end
        S_RED1: begin
          rw[w*WORD_W +: WORD_W] <= t[WORD_W-1:0];
          if (w == 4'(NWORDS - 1)) begin
            p     <= {{ELEM_W{1'b0}}, t[WORD_W-1:0], rw[ELEM_W-WORD_W-1:0]};
            w     <= '0;
            carry <= '0;
            state <= S_RED2;
          end else begin
            carry <= t[37:32];
            w     <= w + 4'd1;
          end
        end
        S_RED2: begin
          rw[w*WORD_W +: WORD_W] <= t[WORD_W-1:0];
          carry <= t[37:32];
          if (w == 4'(NWORDS - 1)) begin
            state <= S_IDLE;
          end else begin
            w <= w + 4'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### test/gf25519_checker.sv
`timescale 1ns / 100ps
// gf25519_checker: watches the item and result channels of gf25519_mul_square_invert,
// predicts each product or inverse in radix 2^51 and compares limb by limb; uses gfm_pkg
module gf25519_checker
  import gfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        command,
  input  logic [LIMB_W-1:0] a_limb0,
  input  logic [LIMB_W-1:0] a_limb1,
  input  logic [LIMB_W-1:0] a_limb2,
  input  logic [LIMB_W-1:0] a_limb3,
  input  logic [LIMB_W-1:0] a_limb4,
  input  logic [LIMB_W-1:0] b_limb0,
  input  logic [LIMB_W-1:0] b_limb1,
  input  logic [LIMB_W-1:0] b_limb2,
  input  logic [LIMB_W-1:0] b_limb3,
  input  logic [LIMB_W-1:0] b_limb4,
  input  logic              done,
  input  logic [LIMB_W-1:0] r_limb0,
  input  logic [LIMB_W-1:0] r_limb1,
  input  logic [LIMB_W-1:0] r_limb2,
  input  logic [LIMB_W-1:0] r_limb3,
  input  logic [LIMB_W-1:0] r_limb4,
  output int                fail_count,
  output int                pending
);

  typedef logic [4:0][LIMB_W-1:0] elem_t;

  localparam logic [127:0] RADIX_MASK = (128'd1 << RADIX) - 1;

  elem_t expected_q[$];

  function automatic elem_t field_mul(elem_t x, elem_t y);
    logic [127:0] col [9];
    logic [127:0] acc [5];
    elem_t r;
    for (int i = 0; i < 9; i++) col[i] = '0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++)
        col[i+j] = col[i+j] + 128'(x[i]) * 128'(y[j]);
    for (int i = 0; i < 8; i++) begin
      col[i+1] = col[i+1] + (col[i] >> RADIX);
      col[i]   = col[i] & RADIX_MASK;
    end
    for (int i = 0; i < 4; i++) acc[i] = col[i] + col[i+5] * 128'(FOLD);
    acc[4] = col[4];
    for (int i = 0; i < 4; i++) begin
      acc[i+1] = acc[i+1] + (acc[i] >> RADIX);
      acc[i]   = acc[i] & RADIX_MASK;
    end
    acc[0] = acc[0] + (acc[4] >> RADIX) * 128'(FOLD);
    acc[4] = acc[4] & RADIX_MASK;
    for (int i = 0; i < 4; i++) begin
      acc[i+1] = acc[i+1] + (acc[i] >> RADIX);
      acc[i]   = acc[i] & RADIX_MASK;
    end
    for (int i = 0; i < 5; i++) r[i] = acc[i][LIMB_W-1:0];
    return r;
  endfunction

  function automatic elem_t field_sqr_n(elem_t x, int n);
    elem_t t;
    t = x;
    for (int k = 0; k < n; k++) t = field_mul(t, t);
    return t;
  endfunction

  // a^(p-2) by the usual 254 squaring / 11 multiply chain
  function automatic elem_t field_inv(elem_t x);
    elem_t e2, e9, e11, c5, c10, c20, c40, c50, c100, c200, c250;
    e2   = field_sqr_n(x, 1);
    e9   = field_mul(field_sqr_n(e2, 2), x);
    e11  = field_mul(e9, e2);
    c5   = field_mul(field_sqr_n(e11, 1), e9);
    c10  = field_mul(field_sqr_n(c5, 5), c5);
    c20  = field_mul(field_sqr_n(c10, 10), c10);
    c40  = field_mul(field_sqr_n(c20, 20), c20);
    c50  = field_mul(field_sqr_n(c40, 10), c10);
    c100 = field_mul(field_sqr_n(c50, 50), c50);
    c200 = field_mul(field_sqr_n(c100, 100), c100);
    c250 = field_mul(field_sqr_n(c200, 50), c50);
    return field_mul(field_sqr_n(c250, 5), e11);
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    elem_t a, b, got, want;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      // result first: a same-edge accept belongs to the next item
      if (done) begin
        got = {r_limb4, r_limb3, r_limb2, r_limb1, r_limb0};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errs++;
        end else begin
          want = expected_q.pop_front();
          for (int i = 0; i < 5; i++)
            if (got[i] !== want[i]) begin
              $display("%0t: limb %0d expected %h actual %h", $time, i, want[i], got[i]);
              errs++;
            end
        end
      end
      if (start && !busy) begin
        a = {a_limb4, a_limb3, a_limb2, a_limb1, a_limb0};
        b = {b_limb4, b_limb3, b_limb2, b_limb1, b_limb0};
        if (command == CMD_MUL)      expected_q.push_back(field_mul(a, b));
        else if (command == CMD_SQR) expected_q.push_back(field_mul(a, a));
        else                         expected_q.push_back(field_inv(a));
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// tb_top: drives multiply, square and invert items into gf25519_mul_square_invert
// with random gaps; gf25519_checker predicts and compares; uses gfm_pkg
module tb_top;
  import gfm_pkg::*;

  typedef logic [4:0][LIMB_W-1:0] elem_t;

  localparam logic [1:0] CMD_INV     = 2'd2;
  localparam logic [1:0] CMD_INV_ALT = 2'd3;
  localparam int N_RANDOM  = 1530;
  localparam int NO_GAP_AT = 1300;
  localparam int WDOG_MAX  = 200000;

  localparam logic [LIMB_W-1:0] ALL_ONES = '1;
  localparam logic [LIMB_W-1:0] R_MAX    = (52'd1 << RADIX) - 1;
  localparam logic [LIMB_W-1:0] R_TOP    = 52'd1 << RADIX;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done;
  logic [1:0] command = CMD_MUL;
  elem_t a_in = '0, b_in = '0, r_out;
  int fail_count, pending, idle_cycles;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  gf25519_mul_square_invert u_dut (
    .clk, .rst, .start, .busy, .command,
    .a_limb0(a_in[0]), .a_limb1(a_in[1]), .a_limb2(a_in[2]),
    .a_limb3(a_in[3]), .a_limb4(a_in[4]),
    .b_limb0(b_in[0]), .b_limb1(b_in[1]), .b_limb2(b_in[2]),
    .b_limb3(b_in[3]), .b_limb4(b_in[4]),
    .done,
    .r_limb0(r_out[0]), .r_limb1(r_out[1]), .r_limb2(r_out[2]),
    .r_limb3(r_out[3]), .r_limb4(r_out[4])
  );

  gf25519_checker u_checker (
    .clk, .rst, .start, .busy, .command,
    .a_limb0(a_in[0]), .a_limb1(a_in[1]), .a_limb2(a_in[2]),
    .a_limb3(a_in[3]), .a_limb4(a_in[4]),
    .b_limb0(b_in[0]), .b_limb1(b_in[1]), .b_limb2(b_in[2]),
    .b_limb3(b_in[3]), .b_limb4(b_in[4]),
    .done,
    .r_limb0(r_out[0]), .r_limb1(r_out[1]), .r_limb2(r_out[2]),
    .r_limb3(r_out[3]), .r_limb4(r_out[4]),
    .fail_count, .pending
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [LIMB_W-1:0] rand_limb();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return R_MAX - LIMB_W'($urandom_range(0, 40));
      3:       return LIMB_W'({$urandom, $urandom}) & R_MAX;
      default: return LIMB_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic elem_t rand_elem();
    elem_t e;
    for (int i = 0; i < 5; i++) e[i] = rand_limb();
    return e;
  endfunction

  function automatic elem_t fill_elem(logic [LIMB_W-1:0] v);
    return {v, v, v, v, v};
  endfunction

  // hold the item until it is taken, then maybe leave a gap
  task automatic send_item(logic [1:0] cmd, elem_t a, elem_t b, bit gaps);
    start   <= 1;
    command <= cmd;
    a_in    <= a;
    b_in    <= b;
    do @(posedge clk); while (busy);
    if (gaps && $urandom_range(0, 2) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  initial begin
    elem_t p_elem, one_elem;
    logic [1:0] cmd;
    p_elem    = fill_elem(R_MAX);
    p_elem[0] = R_MAX - 18;
    one_elem  = '0;
    one_elem[0] = 1;

    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_item(CMD_MUL, '0, '0, 1);
    send_item(CMD_MUL, fill_elem(ALL_ONES), fill_elem(ALL_ONES), 1);
    send_item(CMD_SQR, fill_elem(ALL_ONES), rand_elem(), 0);
    send_item(CMD_MUL, one_elem, rand_elem(), 1);
    send_item(CMD_MUL, fill_elem(R_TOP), fill_elem(R_MAX), 0);
    send_item(CMD_MUL, p_elem, p_elem, 1);
    send_item(CMD_SQR, p_elem, fill_elem(ALL_ONES), 1);
    send_item(CMD_SQR, fill_elem(R_TOP), '0, 0);
    send_item(CMD_MUL, rand_elem(), fill_elem(ALL_ONES), 1);
    send_item(CMD_INV, '0, rand_elem(), 1);
    send_item(CMD_INV, p_elem, '0, 1);
    send_item(CMD_INV_ALT, one_elem, fill_elem(ALL_ONES), 1);
    send_item(CMD_INV, fill_elem(ALL_ONES), rand_elem(), 0);
    send_item(CMD_SQR, rand_elem(), rand_elem(), 1);
    send_item(CMD_MUL, rand_elem(), rand_elem(), 1);

    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 399) == 0)
        cmd = $urandom_range(0, 1) ? CMD_INV : CMD_INV_ALT;
      else
        cmd = $urandom_range(0, 1) ? CMD_MUL : CMD_SQR;
      send_item(cmd, rand_elem(), rand_elem(), n < NO_GAP_AT);
    end
    start <= 0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
